### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on clk with rst_n low as reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ULVL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ULVL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ulvl_pkg.sv
// ----------------------------------------------------------------------------
// ulvl_pkg
// Types, widths and register codes of the ultrasonic level pump controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ulvl_pkg;

    // Counter widths.
    localparam int ECHO_COUNT_BITS   = 16;
    localparam int PERIOD_COUNT_BITS = 24;

    // Widths of the configuration fields and the port.
    localparam int BYTE_W      = 8;
    localparam int PERIOD_W    = 24;
    localparam int SCALE_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    // Width used to compare the phase counter with a configured limit.
    localparam int CMP_W = (PERIOD_COUNT_BITS > PERIOD_W) ? PERIOD_COUNT_BITS : PERIOD_W;

    // Result widths.
    localparam int LEVEL_W = 15;
    localparam int ERR_W   = ECHO_COUNT_BITS + 3;
    localparam int PROD_W  = ECHO_COUNT_BITS + SCALE_W;

    // Saturation limits of the reported level and error.
    localparam int LEVEL_MAX = 16383;
    localparam int LEVEL_MIN = -16384;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SET_POINT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TANK_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LOOP_PERIOD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SCALE       = 3'd5;

    // Register reset values.
    localparam logic [BYTE_W-1:0]   RST_SET_POINT   = 8'd0;
    localparam logic [BYTE_W-1:0]   RST_TANK_HEIGHT = 8'd110;
    localparam logic [BYTE_W-1:0]   RST_DEADBAND    = 8'd10;
    localparam logic [BYTE_W-1:0]   RST_TRIGGER     = 8'd50;
    localparam logic [PERIOD_W-1:0] RST_LOOP_PERIOD = 24'd1000000;
    localparam logic [SCALE_W-1:0]  RST_SCALE       = 16'd11261;

    typedef enum logic [1:0] {
        PH_TRIGGER   = 2'd0,
        PH_WAIT_ECHO = 2'd1,
        PH_COUNT     = 2'd2,
        PH_IDLE      = 2'd3
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   set_point_tenths;
        logic [BYTE_W-1:0]   tank_height_tenths;
        logic [BYTE_W-1:0]   deadband_tenths;
        logic [BYTE_W-1:0]   trigger_ticks;
        logic [PERIOD_W-1:0] loop_period_ticks;
        logic [SCALE_W-1:0]  distance_scale;
    } cfg_regs_t;

    // Sequencer status for the current tick.
    typedef struct packed {
        logic trig;
        logic finish;
    } seq_status_t;

    // Outcome of one completed measurement.
    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic signed [LEVEL_W-1:0] error;
        logic                      drain;
        logic                      fill;
    } calc_res_t;

endpackage

### design/ulvl_cfg.sv
// ----------------------------------------------------------------------------
// ulvl_cfg
// Configuration register file written through the index/data write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ulvl_cfg
    import ulvl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_regs_t              cfg
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    // Decode the register index; unknown indexes are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_SET_POINT:   cfg_next.set_point_tenths   = wr_data[BYTE_W-1:0];
                REG_TANK_HEIGHT: cfg_next.tank_height_tenths = wr_data[BYTE_W-1:0];
                REG_DEADBAND:    cfg_next.deadband_tenths    = wr_data[BYTE_W-1:0];
                REG_TRIGGER:     cfg_next.trigger_ticks      = wr_data[BYTE_W-1:0];
                REG_LOOP_PERIOD: cfg_next.loop_period_ticks  = wr_data[PERIOD_W-1:0];
                REG_SCALE:       cfg_next.distance_scale     = wr_data[SCALE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.set_point_tenths   <= RST_SET_POINT;
            cfg_reg.tank_height_tenths <= RST_TANK_HEIGHT;
            cfg_reg.deadband_tenths    <= RST_DEADBAND;
            cfg_reg.trigger_ticks      <= RST_TRIGGER;
            cfg_reg.loop_period_ticks  <= RST_LOOP_PERIOD;
            cfg_reg.distance_scale     <= RST_SCALE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### design/ulvl_seq.sv
// ----------------------------------------------------------------------------
// ulvl_seq
// Phase sequencer: trigger pulse, echo wait, echo count and loop wait.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ulvl_seq
    import ulvl_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step,
    input  logic                       echo,
    input  cfg_regs_t                  cfg,
    output seq_status_t                status,
    output logic [ECHO_COUNT_BITS-1:0] echo_ticks
);

    localparam logic [PERIOD_COUNT_BITS-1:0] PERIOD_MAX = {PERIOD_COUNT_BITS{1'b1}};
    localparam logic [ECHO_COUNT_BITS-1:0]   ECHO_MAX   = {ECHO_COUNT_BITS{1'b1}};

    phase_t                       phase_reg;
    phase_t                       phase_next;
    logic [PERIOD_COUNT_BITS-1:0] phase_ticks_reg;
    logic [PERIOD_COUNT_BITS-1:0] phase_ticks_next;
    logic [ECHO_COUNT_BITS-1:0]   echo_ticks_reg;
    logic [ECHO_COUNT_BITS-1:0]   echo_ticks_next;

    logic [PERIOD_COUNT_BITS-1:0] tick_inc;
    logic [CMP_W-1:0]             trig_limit;
    logic [CMP_W-1:0]             loop_limit;
    logic                         tick_full;
    logic                         trig_done;
    logic                         loop_done;

    // Saturating phase counter and the end tests of the timed phases.
    // A zero length counts as one tick.
    always_comb
    begin
        tick_inc   = (phase_ticks_reg != PERIOD_MAX) ? phase_ticks_reg + 1'b1
                                                     : phase_ticks_reg;
        tick_full  = (tick_inc == PERIOD_MAX);
        trig_limit = (cfg.trigger_ticks == '0) ? CMP_W'(1) : CMP_W'(cfg.trigger_ticks);
        loop_limit = (cfg.loop_period_ticks == '0) ? CMP_W'(1)
                                                   : CMP_W'(cfg.loop_period_ticks);
        trig_done  = (CMP_W'(tick_inc) >= trig_limit) || tick_full;
        loop_done  = (CMP_W'(tick_inc) >= loop_limit) || tick_full;
    end

    // Next phase and status for the current tick.
    always_comb
    begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        echo_ticks_next  = echo_ticks_reg;
        status           = '0;
        unique case (phase_reg)
            PH_TRIGGER:
            begin
                status.trig = 1'b1;
                if (step)
                begin
                    if (trig_done)
                    begin
                        phase_next       = PH_WAIT_ECHO;
                        phase_ticks_next = '0;
                    end
                    else
                    begin
                        phase_ticks_next = tick_inc;
                    end
                end
            end
            PH_WAIT_ECHO:
            begin
                if (step && echo)
                begin
                    echo_ticks_next = ECHO_COUNT_BITS'(1);
                    phase_next      = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                status.finish = !echo;
                if (step)
                begin
                    if (echo)
                    begin
                        if (echo_ticks_reg != ECHO_MAX)
                        begin
                            echo_ticks_next = echo_ticks_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        phase_next       = PH_IDLE;
                        phase_ticks_next = '0;
                    end
                end
            end
            PH_IDLE:
            begin
                if (step)
                begin
                    if (loop_done)
                    begin
                        phase_next       = PH_TRIGGER;
                        phase_ticks_next = '0;
                    end
                    else
                    begin
                        phase_ticks_next = tick_inc;
                    end
                end
            end
            default:
            begin
                phase_next = PH_TRIGGER;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_TRIGGER;
            phase_ticks_reg <= '0;
            echo_ticks_reg  <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            echo_ticks_reg  <= echo_ticks_next;
        end
    end

    assign echo_ticks = echo_ticks_reg;

endmodule

### design/ulvl_calc.sv
// ----------------------------------------------------------------------------
// ulvl_calc
// Distance, level and error from the echo count, and the deadband decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ulvl_calc
    import ulvl_pkg::*;
(
    input  logic [ECHO_COUNT_BITS-1:0] echo_ticks,
    input  cfg_regs_t                  cfg,
    output calc_res_t                  res
);

    localparam logic signed [ERR_W-1:0] SAT_HI = ERR_W'(LEVEL_MAX);
    localparam logic signed [ERR_W-1:0] SAT_LO = ERR_W'(LEVEL_MIN);

    logic [PROD_W-1:0]          product;
    logic [ECHO_COUNT_BITS-1:0] distance;
    logic signed [ERR_W-1:0]    level;
    logic signed [ERR_W-1:0]    err;
    logic signed [ERR_W-1:0]    band;
    logic                       in_band;
    logic                       err_pos;

    // Clamp a wide value into the 15-bit report range.
    function automatic logic signed [LEVEL_W-1:0] sat15(input logic signed [ERR_W-1:0] v);
        logic signed [LEVEL_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = LEVEL_W'(SAT_HI);
        end
        else if (v < SAT_LO)
        begin
            r = LEVEL_W'(SAT_LO);
        end
        else
        begin
            r = v[LEVEL_W-1:0];
        end
        return r;
    endfunction

    // Distance is the Q16 product of echo ticks and scale.
    assign product  = PROD_W'(echo_ticks) * PROD_W'(cfg.distance_scale);
    assign distance = product[PROD_W-1:SCALE_W];

    // Level and error in tenths of a centimeter.
    assign level = $signed(ERR_W'(cfg.tank_height_tenths)) - $signed(ERR_W'(distance));
    assign err   = level - $signed(ERR_W'(cfg.set_point_tenths));

    // Inside the deadband both pumps stop; otherwise the sign picks the pump.
    assign band    = $signed(ERR_W'(cfg.deadband_tenths));
    assign in_band = (err < band) && (err > -band);
    assign err_pos = (err > $signed(ERR_W'(0)));

    always_comb
    begin
        res.level = sat15(level);
        res.error = sat15(err);
        res.drain = !in_band && err_pos;
        res.fill  = !in_band && !err_pos;
    end

endmodule

### design/ultrasonic_level_deadband_pump_control.sv
// A request accepted into the input register moves on to the result register
// when that is free or draining. Throughput: one request per cycle while the
// result stream does not stall; the path from the echo counter through the
// 16x16 distance multiplier to the pump decision sets the clock period.
// Reset (rst_n low, asynchronous) restores the default registers, the trigger
// phase, zero counters, both pumps off and a zero level and error.
// ----------------------------------------------------------------------------
// ultrasonic_level_deadband_pump_control
// Ultrasonic echo ranging with deadband fill and drain pump control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ultrasonic_level_deadband_pump_control
    import ulvl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Input stream, one request per microsecond tick.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [0] echo_level, [7:1] zero
    // Result stream.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] trigger_out, [1] drain_pump, [2] fill_pump, [17:3] level_tenths,
    // [32:18] level_error_tenths, [33] level_valid, [39:34] zero
    output logic [39:0]            m_tdata,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_regs_t                  cfg;
    seq_status_t                status;
    calc_res_t                  res;
    logic [ECHO_COUNT_BITS-1:0] echo_ticks;

    logic                       in_valid_reg;
    logic                       echo_reg;
    logic                       out_valid_reg;
    logic                       advance;

    logic                       drain_on_reg;
    logic                       drain_on_next;
    logic                       fill_on_reg;
    logic                       fill_on_next;
    logic signed [LEVEL_W-1:0]  last_level_reg;
    logic signed [LEVEL_W-1:0]  last_level_next;
    logic signed [LEVEL_W-1:0]  last_error_reg;
    logic signed [LEVEL_W-1:0]  last_error_next;

    logic                       trig_out_reg;
    logic                       valid_out_reg;
    logic                       drain_out_reg;
    logic                       fill_out_reg;
    logic signed [LEVEL_W-1:0]  level_out_reg;
    logic signed [LEVEL_W-1:0]  error_out_reg;

    assign cfg_ready = 1'b1;

    ulvl_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ulvl_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .echo       (echo_reg),
        .cfg        (cfg),
        .status     (status),
        .echo_ticks (echo_ticks)
    );

    ulvl_calc u_calc (
        .echo_ticks (echo_ticks),
        .cfg        (cfg),
        .res        (res)
    );

    // A held request moves on when the result register is free or draining.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            echo_reg <= s_tdata[0];
        end
    end

    // Pump and measurement state, updated when a measurement completes.
    always_comb
    begin
        drain_on_next   = drain_on_reg;
        fill_on_next    = fill_on_reg;
        last_level_next = last_level_reg;
        last_error_next = last_error_reg;
        if (advance && status.finish)
        begin
            drain_on_next   = res.drain;
            fill_on_next    = res.fill;
            last_level_next = res.level;
            last_error_next = res.error;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_on_reg   <= 1'b0;
            fill_on_reg    <= 1'b0;
            last_level_reg <= '0;
            last_error_reg <= '0;
        end
        else
        begin
            drain_on_reg   <= drain_on_next;
            fill_on_reg    <= fill_on_next;
            last_level_reg <= last_level_next;
            last_error_reg <= last_error_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            trig_out_reg  <= status.trig;
            valid_out_reg <= status.finish;
            drain_out_reg <= drain_on_next;
            fill_out_reg  <= fill_on_next;
            level_out_reg <= last_level_next;
            error_out_reg <= last_error_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, valid_out_reg, error_out_reg, level_out_reg,
                       fill_out_reg, drain_out_reg, trig_out_reg};

    // Checks on the pump state and the result path.
    `ULVL_ASSERT_SAME(a_pumps_exclusive, 1'b1, !(drain_on_reg && fill_on_reg), "both pumps on")
    `ULVL_ASSERT_NEXT(a_pumps_hold, !(advance && status.finish), $stable(drain_on_reg) && $stable(fill_on_reg), "pump changed without a measurement")
    `ULVL_ASSERT_NEXT(a_result_loaded, advance, out_valid_reg, "processed request left no result")
    `ULVL_ASSERT_SAME(a_valid_not_trigger, status.finish, !status.trig, "measurement ends in trigger phase")

endmodule

### bench/tb_ultrasonic_level_deadband_pump_control.sv
// ----------------------------------------------------------------------------
// tb_ultrasonic_level_deadband_pump_control
// Self-checking bench for the echo ranging pump controller. A directed table
// walks reset values, register extremes and the corner cases of the phase
// sequencer. Randomized echo bursts follow under several register settings,
// then a maximum loop period and a long full-scale echo. Every result is
// compared field by field with a table value or a cycle-true sequencer model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ultrasonic_level_deadband_pump_control;

    import ulvl_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 9;
    localparam int IDLE_PERCENT  = 23;
    localparam int STALL_CYCLES  = 300;
    localparam int WATCHDOG_MAX  = 3000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_TICKS   = 110;
    localparam int LONG_ECHO     = 50;
    localparam int SHOW_MAX      = 10;

    localparam logic [PERIOD_COUNT_BITS-1:0] PERIOD_FULL = {PERIOD_COUNT_BITS{1'b1}};
    localparam logic [ECHO_COUNT_BITS-1:0]   ECHO_FULL   = {ECHO_COUNT_BITS{1'b1}};

    // Fields of one result, as carried on m_tdata.
    typedef struct packed {
        logic                      trig;
        logic                      drain;
        logic                      fill;
        logic signed [LEVEL_W-1:0] level;
        logic signed [LEVEL_W-1:0] err;
        logic                      valid;
    } tick_res_t;

    typedef enum logic {ROW_CFG, ROW_TICK} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        logic [CFG_INDEX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0]   data;
        logic                    echo;
        bit                      typed;
        tick_res_t               res;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;   // [0] echo_level, [7:1] zero
    logic                   m_tvalid;
    logic                   m_tready;
    // [0] trigger_out, [1] drain_pump, [2] fill_pump, [17:3] level_tenths,
    // [32:18] level_error_tenths, [33] level_valid, [39:34] zero
    logic [39:0]            m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Model state of the ranging sequencer and its registers.
    cfg_regs_t                 rng_cfg;
    phase_t                    rng_phase;
    logic [PERIOD_COUNT_BITS-1:0] rng_phase_cnt;
    logic [ECHO_COUNT_BITS-1:0]   rng_echo_cnt;
    logic                      rng_drain;
    logic                      rng_fill;
    logic signed [LEVEL_W-1:0] rng_level;
    logic signed [LEVEL_W-1:0] rng_err;

    tick_res_t pending_ticks[$];
    dir_row_t  dir_rows[$];

    bit calm;
    bit rx_hold;
    bit rx_hold_req;
    int errors;
    int shown;
    int n_ticks;
    int n_results;
    int n_writes;
    int n_meas;
    int n_drain;
    int n_fill;
    int quiet_cycles;

    ultrasonic_level_deadband_pump_control uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF clk = ~clk;

    // Clamp a level or error to the 15-bit reporting range.
    function automatic logic signed [LEVEL_W-1:0] clamp_level(input longint v);
        if (v > LEVEL_MAX)
        begin
            return LEVEL_W'(LEVEL_MAX);
        end
        if (v < LEVEL_MIN)
        begin
            return LEVEL_W'(LEVEL_MIN);
        end
        return LEVEL_W'(v);
    endfunction

    // Register write as seen by the model; unknown indexes are ignored.
    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_SET_POINT:   rng_cfg.set_point_tenths   = data[BYTE_W-1:0];
            REG_TANK_HEIGHT: rng_cfg.tank_height_tenths = data[BYTE_W-1:0];
            REG_DEADBAND:    rng_cfg.deadband_tenths    = data[BYTE_W-1:0];
            REG_TRIGGER:     rng_cfg.trigger_ticks      = data[BYTE_W-1:0];
            REG_LOOP_PERIOD: rng_cfg.loop_period_ticks  = data[PERIOD_W-1:0];
            REG_SCALE:       rng_cfg.distance_scale     = data[SCALE_W-1:0];
            default:         ;
        endcase
    endfunction

    // One microsecond tick of the sequencer: advance the model, return the result.
    function automatic tick_res_t range_tick(input logic echo);
        tick_res_t        r;
        logic [CMP_W-1:0] lim;
        longint           distance;
        longint           lvl;
        longint           dev;
        longint           mag;
        r = '0;
        case (rng_phase)
            PH_TRIGGER:
            begin
                r.trig = 1'b1;
                lim = (rng_cfg.trigger_ticks == '0) ? CMP_W'(1) : CMP_W'(rng_cfg.trigger_ticks);
                if (rng_phase_cnt != PERIOD_FULL)
                begin
                    rng_phase_cnt = rng_phase_cnt + 1'b1;
                end
                if (CMP_W'(rng_phase_cnt) >= lim || rng_phase_cnt == PERIOD_FULL)
                begin
                    rng_phase     = PH_WAIT_ECHO;
                    rng_phase_cnt = '0;
                end
            end
            PH_WAIT_ECHO:
            begin
                // The first high sample already counts as one echo tick.
                if (echo)
                begin
                    rng_echo_cnt = ECHO_COUNT_BITS'(1);
                    rng_phase    = PH_COUNT;
                end
            end
            PH_COUNT:
            begin
                if (echo)
                begin
                    if (rng_echo_cnt != ECHO_FULL)
                    begin
                        rng_echo_cnt = rng_echo_cnt + 1'b1;
                    end
                end
                else
                begin
                    distance = (longint'(rng_echo_cnt) * longint'(rng_cfg.distance_scale)) >> 16;
                    lvl  = longint'(rng_cfg.tank_height_tenths) - distance;
                    dev  = lvl - longint'(rng_cfg.set_point_tenths);
                    mag  = (dev < 0) ? -dev : dev;
                    // The pump decision sees the unclamped error.
                    if (mag < longint'(rng_cfg.deadband_tenths))
                    begin
                        rng_drain = 1'b0;
                        rng_fill  = 1'b0;
                    end
                    else if (dev > 0)
                    begin
                        rng_drain = 1'b1;
                        rng_fill  = 1'b0;
                    end
                    else
                    begin
                        rng_drain = 1'b0;
                        rng_fill  = 1'b1;
                    end
                    rng_level     = clamp_level(lvl);
                    rng_err       = clamp_level(dev);
                    r.valid       = 1'b1;
                    rng_phase     = PH_IDLE;
                    rng_phase_cnt = '0;
                end
            end
            default:
            begin
                lim = (rng_cfg.loop_period_ticks == '0) ? CMP_W'(1)
                                                        : CMP_W'(rng_cfg.loop_period_ticks);
                if (rng_phase_cnt != PERIOD_FULL)
                begin
                    rng_phase_cnt = rng_phase_cnt + 1'b1;
                end
                if (CMP_W'(rng_phase_cnt) >= lim || rng_phase_cnt == PERIOD_FULL)
                begin
                    rng_phase     = PH_TRIGGER;
                    rng_phase_cnt = '0;
                end
            end
        endcase
        r.drain = rng_drain;
        r.fill  = rng_fill;
        r.level = rng_level;
        r.err   = rng_err;
        return r;
    endfunction

    // Directed table builders.
    function automatic void add_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        dir_row_t row;
        row       = '{kind: ROW_CFG, idx: idx, data: data, echo: 1'b0, typed: 1'b0, res: '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_tick(input logic echo);
        dir_row_t row;
        row       = '{kind: ROW_TICK, idx: '0, data: '0, echo: echo, typed: 1'b0, res: '0};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_check(input logic echo, input logic trig, input logic drain,
                                      input logic fill, input int level, input int err,
                                      input logic valid);
        dir_row_t row;
        row       = '{kind: ROW_TICK, idx: '0, data: '0, echo: echo, typed: 1'b1, res: '0};
        row.res.trig  = trig;
        row.res.drain = drain;
        row.res.fill  = fill;
        row.res.level = LEVEL_W'(level);
        row.res.err   = LEVEL_W'(err);
        row.res.valid = valid;
        dir_rows.push_back(row);
    endfunction

    // Offer one tick request, with random idle cycles ahead of it.
    task automatic send_tick(input logic echo, input bit use_typed = 1'b0,
                             input tick_res_t typed_res = '0);
        tick_res_t r;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, echo};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        r = range_tick(echo);
        pending_ticks.push_back(use_typed ? typed_res : r);
        n_ticks++;
    endtask

    task automatic send_run(input logic echo, input int count);
        repeat (count)
        begin
            send_tick(echo);
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_ticks.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Register write request; the caller lowers cfg_valid after a group.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        apply_reg(idx, data);
        n_writes++;
    endtask

    // Pick a byte setting, leaning on both ends of its range.
    function automatic logic [BYTE_W-1:0] pick_byte();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return BYTE_W'($urandom);
        endcase
    endfunction

    // Compare one accepted result with the oldest expectation.
    task automatic check_result(input logic [39:0] word);
        tick_res_t want;
        tick_res_t got;
        got.trig  = word[0];
        got.drain = word[1];
        got.fill  = word[2];
        got.level = word[17:3];
        got.err   = word[32:18];
        got.valid = word[33];
        n_results++;
        if (pending_ticks.size() == 0)
        begin
            errors++;
            if (shown < SHOW_MAX)
            begin
                shown++;
                $display("[%0t] unexpected result %h with nothing pending", $time, word);
            end
        end
        else
        begin
            want = pending_ticks.pop_front();
            if (want.valid)
            begin
                n_meas++;
                n_drain += want.drain;
                n_fill  += want.fill;
            end
            if (got.trig !== want.trig || got.drain !== want.drain ||
                got.fill !== want.fill || got.level !== want.level ||
                got.err !== want.err || got.valid !== want.valid)
            begin
                errors++;
                if (shown < SHOW_MAX)
                begin
                    shown++;
                    $display("[%0t] result %0d mismatch:", $time, n_results);
                    $display("    exp trig=%b drain=%b fill=%b level=%0d err=%0d valid=%b",
                             want.trig, want.drain, want.fill,
                             want.level, want.err, want.valid);
                    $display("    got trig=%b drain=%b fill=%b level=%0d err=%0d valid=%b",
                             got.trig, got.drain, got.fill, got.level, got.err, got.valid);
                end
            end
        end
    endtask

    // Result side: check on acceptance, then choose the next ready.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                check_result(m_tdata);
            end
            if (rx_hold)
            begin
                m_tready <= 1'b0;
            end
            else if (calm)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Long receiver hold-off so the block backs up into its input.
    initial
    begin
        rx_hold = 1'b0;
        wait (rx_hold_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (STALL_CYCLES)
        begin
            @(posedge clk);
        end
        rx_hold <= 1'b0;
    end

    // Watchdog on cycles with no accepted request on any channel.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("Watchdog: no progress for %0d cycles", WATCHDOG_MAX);
                $display("FAILURE");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Main stimulus.
    initial
    begin
        int sent;
        int lo;
        int hi;
        int len;
        bit in_cfg;

        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        calm         = 1'b0;
        rx_hold_req  = 1'b0;
        errors       = 0;
        shown        = 0;
        n_ticks      = 0;
        n_results    = 0;
        n_writes     = 0;
        n_meas       = 0;
        n_drain      = 0;
        n_fill       = 0;
        in_cfg       = 1'b0;

        // Model reset state.
        rng_cfg.set_point_tenths   = RST_SET_POINT;
        rng_cfg.tank_height_tenths = RST_TANK_HEIGHT;
        rng_cfg.deadband_tenths    = RST_DEADBAND;
        rng_cfg.trigger_ticks      = RST_TRIGGER;
        rng_cfg.loop_period_ticks  = RST_LOOP_PERIOD;
        rng_cfg.distance_scale     = RST_SCALE;
        rng_phase     = PH_TRIGGER;
        rng_phase_cnt = '0;
        rng_echo_cnt  = '0;
        rng_drain     = 1'b0;
        rng_fill      = 1'b0;
        rng_level     = '0;
        rng_err       = '0;

        // Directed table. Right after reset the trigger is driven and all else is zero.
        add_check(1'b1, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
        add_check(1'b0, 1'b1, 1'b0, 1'b0, 0, 0, 1'b0);
        // Zero trigger length and zero loop period both act as one tick.
        add_cfg(REG_TRIGGER, 24'h0);
        add_cfg(REG_LOOP_PERIOD, 24'h0);
        // Highest tank, no set point, no deadband, full scale; upper data bits dropped.
        add_cfg(REG_TANK_HEIGHT, 24'hFFFFFF);
        add_cfg(REG_SET_POINT, 24'h0);
        add_cfg(REG_DEADBAND, 24'h0);
        add_cfg(REG_SCALE, 24'h00FFFF);
        add_tick(1'b0);
        add_tick(1'b1);
        add_check(1'b0, 1'b0, 1'b1, 1'b0, 255, 255, 1'b1);
        add_tick(1'b0);
        // Empty tank at the top set point with the widest deadband still fills.
        add_cfg(REG_SET_POINT, 24'hFF);
        add_cfg(REG_TANK_HEIGHT, 24'h0);
        add_cfg(REG_DEADBAND, 24'hFF);
        add_cfg(REG_SCALE, 24'h0);
        add_tick(1'b1);
        add_tick(1'b0);
        add_tick(1'b0);
        add_tick(1'b1);
        add_tick(1'b1);
        add_check(1'b0, 1'b0, 1'b0, 1'b1, 0, -255, 1'b1);
        // Writes to unused indexes change nothing.
        add_cfg(3'd6, 24'hFFFFFF);
        add_cfg(3'd7, 24'hFFFFFF);
        // Zero error with no deadband turns on the fill pump.
        add_cfg(REG_SET_POINT, 24'd110);
        add_cfg(REG_TANK_HEIGHT, 24'd110);
        add_cfg(REG_DEADBAND, 24'd0);
        add_cfg(REG_SCALE, 24'd11261);
        add_tick(1'b0);
        add_tick(1'b0);
        add_tick(1'b1);
        add_tick(1'b0);
        // The same reading inside a deadband turns both pumps off.
        add_cfg(REG_DEADBAND, 24'd10);
        add_tick(1'b0);
        add_tick(1'b0);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b1);
        add_tick(1'b0);

        repeat (RESET_CYCLES)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table.
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                if (!in_cfg)
                begin
                    settle();
                end
                write_reg(dir_rows[i].idx, dir_rows[i].data);
                in_cfg = 1'b1;
            end
            else
            begin
                if (in_cfg)
                begin
                    cfg_valid <= 1'b0;
                    in_cfg = 1'b0;
                end
                send_tick(dir_rows[i].echo, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        // Random phases, each under a fresh register setting.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            calm <= (p == 2);
            write_reg(REG_SET_POINT,   {16'($urandom), pick_byte()});
            write_reg(REG_TANK_HEIGHT, {16'($urandom), pick_byte()});
            write_reg(REG_DEADBAND,    {16'($urandom), pick_byte()});
            case ($urandom_range(0, 7))
                0:       write_reg(REG_TRIGGER, {16'($urandom), 8'd0});
                1:       write_reg(REG_TRIGGER, {16'($urandom), 8'd255});
                default: write_reg(REG_TRIGGER, {16'($urandom), 8'($urandom_range(1, 12))});
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(REG_LOOP_PERIOD, 24'd0);
                1:       write_reg(REG_LOOP_PERIOD, 24'd1);
                default: write_reg(REG_LOOP_PERIOD, 24'($urandom_range(2, 30)));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(REG_SCALE, {8'($urandom), 16'h0000});
                1:       write_reg(REG_SCALE, {8'($urandom), 16'hFFFF});
                default: write_reg(REG_SCALE, 24'($urandom));
            endcase
            cfg_valid <= 1'b0;
            if (p == 1)
            begin
                rx_hold_req = 1'b1;
            end
            sent = 0;
            while (sent < PHASE_TICKS)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    // Well-formed echo: a quiet gap, then one high pulse.
                    lo = $urandom_range(0, 10);
                    hi = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 400)
                                                     : $urandom_range(1, 60);
                    send_run(1'b0, lo);
                    send_run(1'b1, hi);
                    sent += lo + hi;
                end
                else
                begin
                    len = $urandom_range(1, 8);
                    repeat (len)
                    begin
                        send_tick(1'($urandom_range(0, 1)));
                    end
                    sent += len;
                end
            end
        end

        // Longest loop period: get into the idle phase, then cut it short.
        settle();
        calm <= 1'b0;
        write_reg(REG_TRIGGER, 24'd2);
        write_reg(REG_LOOP_PERIOD, 24'hFFFFFF);
        cfg_valid <= 1'b0;
        while (rng_phase != PH_IDLE)
        begin
            send_tick((rng_phase == PH_COUNT) ? ($urandom_range(0, 3) != 0) : 1'b1);
        end
        repeat (40)
        begin
            send_tick(1'($urandom_range(0, 1)));
        end
        settle();
        write_reg(REG_LOOP_PERIOD, 24'd5);
        cfg_valid <= 1'b0;
        repeat (20)
        begin
            send_tick(1'($urandom_range(0, 1)));
        end

        // Long echo at full scale against an empty tank and the top set point.
        settle();
        write_reg(REG_TRIGGER, 24'd1);
        write_reg(REG_LOOP_PERIOD, 24'd1);
        write_reg(REG_SCALE, 24'h00FFFF);
        write_reg(REG_TANK_HEIGHT, 24'd0);
        write_reg(REG_SET_POINT, 24'd255);
        write_reg(REG_DEADBAND, 24'd0);
        cfg_valid <= 1'b0;
        send_run(1'b0, 3);
        send_run(1'b1, LONG_ECHO);
        send_run(1'b0, 3);

        // Drain and let any stray result show up.
        settle();
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (pending_ticks.size() != 0)
        begin
            errors += pending_ticks.size();
            $display("%0d expected results never arrived", pending_ticks.size());
        end

        $display("Ran %0d ticks and %0d register writes; %0d measurements, %0d drain, %0d fill.",
                 n_ticks, n_writes, n_meas, n_drain, n_fill);
        $display("Checked %0d results, %0d failed.", n_results, errors);
        if (errors == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
+incdir+design
design/ulvl_pkg.sv
design/ulvl_cfg.sv
design/ulvl_seq.sv
design/ulvl_calc.sv
design/ultrasonic_level_deadband_pump_control.sv
bench/tb_ultrasonic_level_deadband_pump_control.sv
